// File: src/tga_rle_image_decoder_macros.svh
// ---------------------------------------------------------------------------
// tga rle image decoder assertion macros
// shared assertion wrappers, clocked on clk_i and quiet during reset
// ---------------------------------------------------------------------------
`ifndef TGA_RLE_IMAGE_DECODER_MACROS_SVH
`define TGA_RLE_IMAGE_DECODER_MACROS_SVH

// property that must hold at every edge out of reset
`define TGA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after its antecedent
`define TGA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/tga_pkg.sv
// ---------------------------------------------------------------------------
// tga decoder package
// result kinds, header constants and the result word type
// ---------------------------------------------------------------------------
package tga_pkg;

  typedef enum logic [1:0] {
    KIND_RUN      = 2'd0,
    KIND_INFO     = 2'd1,
    KIND_BADHDR   = 2'd2,
    KIND_BADDEPTH = 2'd3
  } kind_e;

  // image type codes in header byte 2
  localparam logic [7:0] TYPE_RAW = 8'h02;
  localparam logic [7:0] TYPE_RLE = 8'h0A;

  // supported depths
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // header byte positions
  localparam logic [4:0] HDR_TYPE_IDX  = 5'd2;
  localparam logic [4:0] HDR_ID_LEN    = 5'd12;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic [7:0]  chan3;
    logic [7:0]  run_count;
    logic        last_pixel;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [7:0]  depth_bits;
  } result_t;

endpackage

// File: src/tga_if.sv
// ---------------------------------------------------------------------------
// tga decoder stream interfaces
// valid/ready channels for file bytes in and decoded words out
// ---------------------------------------------------------------------------
interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface tga_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  chan0;
  logic [7:0]  chan1;
  logic [7:0]  chan2;
  logic [7:0]  chan3;
  logic [7:0]  run_count;
  logic        last_pixel;
  logic [15:0] img_width;
  logic [15:0] img_height;
  logic [7:0]  depth_bits;

  modport source (
    output valid, output kind, output chan0, output chan1, output chan2, output chan3,
    output run_count, output last_pixel, output img_width, output img_height,
    output depth_bits, input ready
  );
  modport sink (
    input valid, input kind, input chan0, input chan1, input chan2, input chan3,
    input run_count, input last_pixel, input img_width, input img_height,
    input depth_bits, output ready
  );
endinterface

// File: src/tga_result_reg.sv
// ---------------------------------------------------------------------------
// tga result register
// holds one decoded word until the downstream side takes it
// ---------------------------------------------------------------------------
module tga_result_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             res_vld_i,
  input  tga_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             ready_o,
  output logic             valid_o,
  output tga_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  tga_pkg::result_t res_q;

  // free when empty or being drained this cycle
  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    if (adv_i) begin
      valid_d = res_vld_i;
    end else begin
      valid_d = valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: src/tga_rle_image_decoder.sv
// ---------------------------------------------------------------------------
// tga rle image decoder
// truecolor tga decoder (raw and run-length) emitting an info word and runs
// ---------------------------------------------------------------------------
// Takes one file byte per clock and sustains one byte per clock with no
// bubbles while out_o is not stalled. A byte sits in the input register
// while a single pass of decode logic (header check, packet and pixel
// assembly, run clip) updates the decoder state and loads the result
// register, from which the word drives out_o. The input register
// keeps taking bytes while a finished word waits in the result register;
// only a word that is both waiting and blocked stops input. Every byte
// yields zero or one word. Header bytes 0..11 must match the raw (type 2)
// or run-length (type 10) template, else a bad-header word is sent and
// the decoder halts; a depth other than 24 or 32 gives a bad-depth word
// and halts. On byte 17 an info word carries width, height and depth,
// then one run word per pixel: raw images swap B,G,R to R,G,B, run-length
// images keep file order, a missing alpha reads 0. Repeat packets give one
// word with a count of 1..128 clipped to the pixels left. file_start on a
// byte restarts decoding with that byte as header byte 0.
// ---------------------------------------------------------------------------
module tga_rle_image_decoder (
  input  logic clk_i,
  input  logic rst_ni,
  tga_in_if.sink    in_i,
  tga_out_if.source out_o
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_HALT   = 2'd2
  } phase_e;

  // input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       start_q;

  // decoder state
  phase_e      phase_q, phase_d;
  logic [4:0]  hdr_idx_q, hdr_idx_d;
  logic        comp_q, comp_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        four_q, four_d;
  logic [31:0] pix_left_q, pix_left_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic        pkt_rep_q, pkt_rep_d;
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [23:0] pix_bytes_q, pix_bytes_d;

  // state as seen by this byte (file_start acts as a restart)
  phase_e      phase_c;
  logic [4:0]  hdr_idx_c;
  logic        comp_c;
  logic [15:0] width_c;
  logic [15:0] height_c;
  logic        four_c;
  logic [31:0] pix_left_c;
  logic [7:0]  pkt_left_c;
  logic        pkt_rep_c;
  logic [1:0]  byte_pos_c;
  logic [23:0] pix_bytes_c;

  logic             fire;
  logic             res_ready;
  logic             res_vld;
  tga_pkg::result_t res;
  tga_pkg::result_t res_q;
  logic             out_vld;

  // working values for the pixel path
  logic       hdr_ok;
  logic [1:0] last_pos;
  logic [7:0] b0, b1, b2, alpha;
  logic [7:0] run;

  // a byte moves on when the result register can take its word
  assign fire       = in_vld_q && res_ready;
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.data_byte;
      start_q <= in_i.file_start;
    end
  end

  always_comb begin
    phase_c     = start_q ? PH_HEADER : phase_q;
    hdr_idx_c   = start_q ? 5'd0 : hdr_idx_q;
    comp_c      = start_q ? 1'b0 : comp_q;
    width_c     = start_q ? 16'd0 : width_q;
    height_c    = start_q ? 16'd0 : height_q;
    four_c      = start_q ? 1'b0 : four_q;
    pix_left_c  = start_q ? 32'd0 : pix_left_q;
    pkt_left_c  = start_q ? 8'd0 : pkt_left_q;
    pkt_rep_c   = start_q ? 1'b0 : pkt_rep_q;
    byte_pos_c  = start_q ? 2'd0 : byte_pos_q;
    pix_bytes_c = start_q ? 24'd0 : pix_bytes_q;
  end

  // single-pass decode of one byte
  always_comb begin
    phase_d     = phase_c;
    hdr_idx_d   = hdr_idx_c;
    comp_d      = comp_c;
    width_d     = width_c;
    height_d    = height_c;
    four_d      = four_c;
    pix_left_d  = pix_left_c;
    pkt_left_d  = pkt_left_c;
    pkt_rep_d   = pkt_rep_c;
    byte_pos_d  = byte_pos_c;
    pix_bytes_d = pix_bytes_c;
    res         = '0;
    res_vld     = 1'b0;
    hdr_ok      = 1'b1;
    last_pos    = four_c ? 2'd3 : 2'd2;
    b0          = pix_bytes_c[7:0];
    b1          = pix_bytes_c[15:8];
    b2          = four_c ? pix_bytes_c[23:16] : byte_q;
    alpha       = four_c ? byte_q : 8'd0;
    run         = 8'd1;

    unique case (phase_c)
      PH_HEADER: begin
        if (hdr_idx_c < tga_pkg::HDR_ID_LEN) begin
          // id, colormap and origin bytes must be zero, type must be 2 or 10
          if (hdr_idx_c == tga_pkg::HDR_TYPE_IDX) begin
            hdr_ok = (byte_q == tga_pkg::TYPE_RAW) || (byte_q == tga_pkg::TYPE_RLE);
            comp_d = (byte_q == tga_pkg::TYPE_RLE);
          end else begin
            hdr_ok = (byte_q == 8'd0);
          end
          if (!hdr_ok) begin
            res.kind = tga_pkg::KIND_BADHDR;
            res_vld  = 1'b1;
            phase_d  = PH_HALT;
          end else begin
            hdr_idx_d = hdr_idx_c + 5'd1;
          end
        end else begin
          unique case (hdr_idx_c)
            tga_pkg::HDR_WIDTH_LO: begin
              width_d   = {8'd0, byte_q};
              hdr_idx_d = hdr_idx_c + 5'd1;
            end
            tga_pkg::HDR_WIDTH_HI: begin
              width_d   = {byte_q, width_c[7:0]};
              hdr_idx_d = hdr_idx_c + 5'd1;
            end
            tga_pkg::HDR_HEIGHT_LO: begin
              height_d  = {8'd0, byte_q};
              hdr_idx_d = hdr_idx_c + 5'd1;
            end
            tga_pkg::HDR_HEIGHT_HI: begin
              height_d  = {byte_q, height_c[7:0]};
              hdr_idx_d = hdr_idx_c + 5'd1;
            end
            tga_pkg::HDR_DEPTH: begin
              if (byte_q == tga_pkg::DEPTH_24) begin
                four_d    = 1'b0;
                hdr_idx_d = hdr_idx_c + 5'd1;
              end else if (byte_q == tga_pkg::DEPTH_32) begin
                four_d    = 1'b1;
                hdr_idx_d = hdr_idx_c + 5'd1;
              end else begin
                res.kind       = tga_pkg::KIND_BADDEPTH;
                res.img_width  = width_c;
                res.img_height = height_c;
                res.depth_bits = byte_q;
                res_vld        = 1'b1;
                phase_d        = PH_HALT;
              end
            end
            default: begin
              // descriptor byte closes the header
              pix_left_d     = {16'd0, width_c} * {16'd0, height_c};
              res.kind       = tga_pkg::KIND_INFO;
              res.img_width  = width_c;
              res.img_height = height_c;
              res.depth_bits = four_c ? tga_pkg::DEPTH_32 : tga_pkg::DEPTH_24;
              res_vld        = 1'b1;
              if ((width_c == 16'd0) || (height_c == 16'd0)) begin
                res.last_pixel = 1'b1;
                phase_d        = PH_HALT;
              end else begin
                phase_d     = PH_DATA;
                pkt_left_d  = 8'd0;
                pkt_rep_d   = 1'b0;
                byte_pos_d  = 2'd0;
                pix_bytes_d = 24'd0;
              end
            end
          endcase
        end
      end

      PH_DATA: begin
        if (comp_c && (pkt_left_c == 8'd0)) begin
          // packet header: low seven bits plus one, top bit marks a repeat
          pkt_left_d = {1'b0, byte_q[6:0]} + 8'd1;
          pkt_rep_d  = byte_q[7];
        end else if (byte_pos_c < last_pos) begin
          case (byte_pos_c)
            2'd0:    pix_bytes_d = {16'd0, byte_q};
            2'd1:    pix_bytes_d[15:8] = byte_q;
            default: pix_bytes_d[23:16] = byte_q;
          endcase
          byte_pos_d = byte_pos_c + 2'd1;
        end else begin
          byte_pos_d = 2'd0;
          if (comp_c && pkt_rep_c) begin
            // clip the repeat to what remains of the image
            if ({24'd0, pkt_left_c} > pix_left_c) begin
              run = pix_left_c[7:0];
            end else begin
              run = pkt_left_c;
            end
            pkt_left_d = 8'd0;
          end else begin
            run = 8'd1;
            if (comp_c) begin
              pkt_left_d = pkt_left_c - 8'd1;
            end
          end
          pix_left_d    = pix_left_c - {24'd0, run};
          res.kind      = tga_pkg::KIND_RUN;
          res.chan0     = comp_c ? b0 : b2;
          res.chan1     = b1;
          res.chan2     = comp_c ? b2 : b0;
          res.chan3     = alpha;
          res.run_count = run;
          res_vld       = 1'b1;
          if (pix_left_d == 32'd0) begin
            res.last_pixel = 1'b1;
            phase_d        = PH_HALT;
          end
        end
      end

      default: begin
        // halted: bytes are dropped until file_start
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_idx_q   <= 5'd0;
      comp_q      <= 1'b0;
      width_q     <= 16'd0;
      height_q    <= 16'd0;
      four_q      <= 1'b0;
      pix_left_q  <= 32'd0;
      pkt_left_q  <= 8'd0;
      pkt_rep_q   <= 1'b0;
      byte_pos_q  <= 2'd0;
      pix_bytes_q <= 24'd0;
    end else if (fire) begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      comp_q      <= comp_d;
      width_q     <= width_d;
      height_q    <= height_d;
      four_q      <= four_d;
      pix_left_q  <= pix_left_d;
      pkt_left_q  <= pkt_left_d;
      pkt_rep_q   <= pkt_rep_d;
      byte_pos_q  <= byte_pos_d;
      pix_bytes_q <= pix_bytes_d;
    end
  end

  tga_result_reg u_result_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (fire),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .ready_o     (res_ready),
    .valid_o     (out_vld),
    .res_o       (res_q)
  );

  assign out_o.valid      = out_vld;
  assign out_o.kind       = res_q.kind;
  assign out_o.chan0      = res_q.chan0;
  assign out_o.chan1      = res_q.chan1;
  assign out_o.chan2      = res_q.chan2;
  assign out_o.chan3      = res_q.chan3;
  assign out_o.run_count  = res_q.run_count;
  assign out_o.last_pixel = res_q.last_pixel;
  assign out_o.img_width  = res_q.img_width;
  assign out_o.img_height = res_q.img_height;
  assign out_o.depth_bits = res_q.depth_bits;

endmodule

// File: src/tga_checker.sv
// ---------------------------------------------------------------------------
// tga decoder port checker
// checks the output word stream of the decoder, bound to the top level
// ---------------------------------------------------------------------------
`include "tga_rle_image_decoder_macros.svh"

module tga_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [1:0]  kind_i,
  input logic [7:0]  chan0_i,
  input logic [7:0]  chan3_i,
  input logic [7:0]  run_count_i,
  input logic        last_pixel_i,
  input logic [15:0] img_width_i,
  input logic [15:0] img_height_i,
  input logic [7:0]  depth_bits_i
);

  // a stalled word keeps its contents
  `TGA_ASSERT_NEXT(a_out_hold, valid_i && !ready_i, valid_i && $stable({kind_i, chan0_i, chan3_i, run_count_i, last_pixel_i, img_width_i, img_height_i, depth_bits_i}), "output word changed while stalled")

  // run words carry a count of 1..128 and no header fields
  `TGA_ASSERT(a_run_shape, !(valid_i && (kind_i == tga_pkg::KIND_RUN)) || ((run_count_i != 8'd0) && (run_count_i <= 8'd128) && (img_width_i == 16'd0) && (img_height_i == 16'd0) && (depth_bits_i == 8'd0)), "malformed run word")

  // bad depth reports an unsupported depth
  `TGA_ASSERT(a_bad_depth, !(valid_i && (kind_i == tga_pkg::KIND_BADDEPTH)) || ((depth_bits_i != tga_pkg::DEPTH_24) && (depth_bits_i != tga_pkg::DEPTH_32)), "bad depth word with a supported depth")

  // an info word ends the image only when it is empty
  `TGA_ASSERT(a_empty_info, !(valid_i && (kind_i == tga_pkg::KIND_INFO) && last_pixel_i) || ((img_width_i == 16'd0) || (img_height_i == 16'd0)), "info word closed a non-empty image")

endmodule

bind tga_rle_image_decoder tga_checker u_tga_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (out_o.valid),
  .ready_i      (out_o.ready),
  .kind_i       (out_o.kind),
  .chan0_i      (out_o.chan0),
  .chan3_i      (out_o.chan3),
  .run_count_i  (out_o.run_count),
  .last_pixel_i (out_o.last_pixel),
  .img_width_i  (out_o.img_width),
  .img_height_i (out_o.img_height),
  .depth_bits_i (out_o.depth_bits)
);
